// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the execute unit core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RVM_ASSERT(lbl, prop)
`define RVM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/rvm_pkg.sv =====
// types and constants of the register machine execute unit
`default_nettype none

package rvm_pkg;

  localparam int FUNC_W       = 5;
  localparam int IDX_W        = 4;
  localparam int DATA_W       = 32;
  localparam int LABEL_W      = 31;
  localparam int ERR_W        = 2;
  localparam int CNT_W        = 5;
  localparam int NUM_REGS_DEF = 16;

  localparam logic [LABEL_W-1:0] LABEL_BASE = 31'h7fff_ffff;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV0    = 2'd2;

  localparam int FLAG_EQ = 0;
  localparam int FLAG_LT = 1;
  localparam int FLAG_GT = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_NOP     = 5'd0,
    FN_MOV     = 5'd1,
    FN_MOVI    = 5'd2,
    FN_INC     = 5'd3,
    FN_CMP     = 5'd4,
    FN_CMPI    = 5'd5,
    FN_JE      = 5'd6,
    FN_JNE     = 5'd7,
    FN_JMP     = 5'd8,
    FN_OUT     = 5'd9,
    FN_XOR     = 5'd10,
    FN_XORI    = 5'd11,
    FN_ADD     = 5'd12,
    FN_ADDI    = 5'd13,
    FN_SUB     = 5'd14,
    FN_SUBI    = 5'd15,
    FN_MUL     = 5'd16,
    FN_MULI    = 5'd17,
    FN_DIV     = 5'd18,
    FN_DIVI    = 5'd19,
    FN_OR      = 5'd20,
    FN_ORI     = 5'd21,
    FN_AND     = 5'd22,
    FN_ANDI    = 5'd23,
    FN_MOD     = 5'd24,
    FN_MODI    = 5'd25,
    FN_NOT     = 5'd26,
    FN_JL      = 5'd27,
    FN_JLE     = 5'd28,
    FN_JG      = 5'd29,
    FN_JGE     = 5'd30,
    FN_INVALID = 5'd31
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/register_vm_execute_unit_core.sv =====
// execute unit of a small register machine with an iterative divider
//
// input channel (in_valid / in_stall) carries one decoded instruction per item;
// the result channel (out_valid / out_stall) returns exactly one item for each:
// print value, taken-branch target and error code.
// an item is taken when in_stall is low, i.e. the sequencer is idle; it then
// reads both operands from the register file and runs the execute state.
// simple instructions then pass through the done state back to idle; the
// result reaches the output register as the done state is left.
// div and mod run a restoring divider, one quotient bit per cycle for all 32
// quotient bits, then a sign fix state, before the done state.
// the result sits in an output register; the sequencer only waits if that
// register is still full and out_stall is high when the next result is ready.
// register writes land when the result moves into the output register.
// synchronous reset (rst_n low) clears the output valid, the compare flags and the
// per-register valid bits, so every register reads as zero until written.
// register indexes not below NUM_REGS read as zero and are never written.
`default_nettype none
`include "assert_macros.svh"

module register_vm_execute_unit_core #(
  parameter int NUM_REGS = rvm_pkg::NUM_REGS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rvm_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [rvm_pkg::IDX_W-1:0]           in_dst_reg,
  input  wire logic [rvm_pkg::IDX_W-1:0]           in_src_reg,
  input  wire logic signed [rvm_pkg::DATA_W-1:0]   in_immediate,
  input  wire logic [rvm_pkg::LABEL_W-1:0]         in_label_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_print_valid,
  output logic signed [rvm_pkg::DATA_W-1:0]        out_print_value,
  output logic                                     out_branch_taken,
  output logic [rvm_pkg::LABEL_W-1:0]              out_branch_target,
  output logic [rvm_pkg::ERR_W-1:0]                out_error_code
);
  import rvm_pkg::*;

  localparam int AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CMP_W = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // register file with per-entry valid bits
  logic [DATA_W-1:0]   rf_r [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          flags_r, flags_nxt;

  func_t               func_r;
  logic [DATA_W-1:0]   imm_r;
  logic [LABEL_W-1:0]  label_r;
  logic [AW-1:0]       d_addr_r;
  logic                d_ok_r;
  logic [DATA_W-1:0]   qa_r, qb_r;
  logic                va_r, vb_r;

  logic [DATA_W-1:0]   res_r, res_nxt;
  logic                wr_en_r, wr_en_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;
  logic                pv_r, pv_nxt;
  logic                bt_r, bt_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   bmag_r, bmag_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                in_acc;
  logic                out_load;
  logic                rf_we;
  logic [CMP_W-1:0]    d_ext, s_ext;
  logic                d_ok, s_ok;
  logic [AW-1:0]       d_addr, s_addr;
  logic [DATA_W-1:0]   a_w, rs_w, b_w;
  logic [DATA_W-1:0]   a_mag, b_mag;
  logic                use_imm;
  logic [2*DATA_W-1:0] prod_w;
  logic [DATA_W:0]     shifted_w, trial_w;
  logic                is_mod;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign d_ext  = CMP_W'(in_dst_reg);
  assign s_ext  = CMP_W'(in_src_reg);
  assign d_ok   = d_ext < CMP_W'(NUM_REGS);
  assign s_ok   = s_ext < CMP_W'(NUM_REGS);
  assign d_addr = d_ext[AW-1:0];
  assign s_addr = s_ext[AW-1:0];

  assign a_w     = va_r ? qa_r : '0;
  assign rs_w    = vb_r ? qb_r : '0;
  assign use_imm = (func_r == FN_MOVI) || (func_r == FN_CMPI) ||
                   (func_r[0] && (func_r != FN_MOV));
  assign b_w     = use_imm ? imm_r : rs_w;
  assign a_mag   = a_w[DATA_W-1] ? (DATA_W'(0) - a_w) : a_w;
  assign b_mag   = b_w[DATA_W-1] ? (DATA_W'(0) - b_w) : b_w;
  assign prod_w  = a_w * b_w;
  assign is_mod  = (func_r == FN_MOD) || (func_r == FN_MODI);

  // one restoring divide step
  assign shifted_w = {rem_r, quo_r[DATA_W-1]};
  assign trial_w   = shifted_w - {1'b0, bmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[d_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_r[d_addr_r] <= res_r;
    end
    if (in_acc) begin
      qa_r <= rf_r[d_addr];
      qb_r <= rf_r[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= func_t'(in_func);
      imm_r    <= in_immediate;
      label_r  <= in_label_word;
      d_addr_r <= d_addr;
      d_ok_r   <= d_ok;
      va_r     <= d_ok && rf_vld_r[d_addr];
      vb_r     <= s_ok && rf_vld_r[s_addr];
    end
    res_r   <= res_nxt;
    wr_en_r <= wr_en_nxt;
    err_r   <= err_nxt;
    pv_r    <= pv_nxt;
    bt_r    <= bt_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    bmag_r  <= bmag_nxt;
    cnt_r   <= cnt_nxt;
    if (out_load) begin
      out_print_valid   <= pv_r;
      out_print_value   <= pv_r ? $signed(res_r) : '0;
      out_branch_taken  <= bt_r;
      out_branch_target <= bt_r ? (LABEL_BASE - label_r) : '0;
      out_error_code    <= err_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    flags_nxt     = flags_r;
    res_nxt       = res_r;
    wr_en_nxt     = wr_en_r;
    err_nxt       = err_r;
    pv_nxt        = pv_r;
    bt_nxt        = bt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bmag_nxt      = bmag_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    rf_we         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wr_en_nxt = 1'b0;
        err_nxt   = ERR_NONE;
        pv_nxt    = 1'b0;
        bt_nxt    = 1'b0;
        res_nxt   = '0;
        state_nxt = ST_DONE;
        unique case (func_r) inside
          FN_NOP: begin
          end
          FN_MOV, FN_MOVI: begin
            res_nxt   = b_w;
            wr_en_nxt = 1'b1;
          end
          FN_INC: begin
            res_nxt   = a_w + DATA_W'(1);
            wr_en_nxt = 1'b1;
          end
          FN_CMP, FN_CMPI: begin
            flags_nxt[FLAG_EQ] = (a_w == b_w);
            flags_nxt[FLAG_LT] = ($signed(a_w) < $signed(b_w));
            flags_nxt[FLAG_GT] = ($signed(a_w) > $signed(b_w));
          end
          FN_JE:  bt_nxt = flags_r[FLAG_EQ];
          FN_JNE: bt_nxt = !flags_r[FLAG_EQ];
          FN_JMP: bt_nxt = 1'b1;
          FN_JL:  bt_nxt = flags_r[FLAG_LT];
          FN_JLE: bt_nxt = flags_r[FLAG_LT] || flags_r[FLAG_EQ];
          FN_JG:  bt_nxt = flags_r[FLAG_GT];
          FN_JGE: bt_nxt = flags_r[FLAG_GT] || flags_r[FLAG_EQ];
          FN_OUT: begin
            pv_nxt  = 1'b1;
            res_nxt = a_w;
          end
          FN_XOR, FN_XORI: begin
            res_nxt   = a_w ^ b_w;
            wr_en_nxt = 1'b1;
          end
          FN_ADD, FN_ADDI: begin
            res_nxt   = a_w + b_w;
            wr_en_nxt = 1'b1;
          end
          FN_SUB, FN_SUBI: begin
            res_nxt   = a_w - b_w;
            wr_en_nxt = 1'b1;
          end
          FN_MUL, FN_MULI: begin
            res_nxt   = prod_w[DATA_W-1:0];
            wr_en_nxt = 1'b1;
          end
          FN_DIV, FN_DIVI, FN_MOD, FN_MODI: begin
            if (b_w == '0) begin
              err_nxt = ERR_DIV0;
            end else begin
              rem_nxt   = '0;
              quo_nxt   = a_mag;
              bmag_nxt  = b_mag;
              cnt_nxt   = '1;
              state_nxt = ST_DIV;
            end
          end
          FN_OR, FN_ORI: begin
            res_nxt   = a_w | b_w;
            wr_en_nxt = 1'b1;
          end
          FN_AND, FN_ANDI: begin
            res_nxt   = a_w & b_w;
            wr_en_nxt = 1'b1;
          end
          FN_NOT: begin
            res_nxt   = ~a_w;
            wr_en_nxt = 1'b1;
          end
          default: begin
            err_nxt = ERR_INVALID;
          end
        endcase
      end
      ST_DIV: begin
        if (!trial_w[DATA_W]) begin
          rem_nxt = trial_w[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted_w[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (is_mod) begin
          res_nxt = a_w[DATA_W-1] ? (DATA_W'(0) - rem_r) : rem_r;
        end else begin
          res_nxt = (a_w[DATA_W-1] ^ b_w[DATA_W-1]) ? (DATA_W'(0) - quo_r) : quo_r;
        end
        wr_en_nxt = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          rf_we         = wr_en_r && d_ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `RVM_ASSERT_NEXT(a_accept_exec, in_acc, state_r == ST_EXEC)
  `RVM_ASSERT_NEXT(a_out_only_from_done, (state_r != ST_DONE) && !out_valid_r, !out_valid_r)
  `RVM_ASSERT_NEXT(a_div_ends, (state_r == ST_DIV) && (cnt_r == '0), state_r == ST_FIX)
  `RVM_ASSERT(a_err_no_write, (state_r == ST_DONE) && (err_r != ERR_NONE) |-> !wr_en_r)
  `RVM_ASSERT(a_err_no_side, out_valid_r && (out_error_code != ERR_NONE) |-> !out_print_valid && !out_branch_taken)

endmodule

`default_nettype wire
